// File: rtl/sfc_pkg.sv
// shared types and constants of the sync frame crc32 checker
package sfc_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned CrcW      = 32;
    localparam int unsigned PosW      = 9;
    localparam int unsigned CfgIndexW = 2;

    localparam logic [CrcW-1:0]  CrcPoly     = 32'hEDB8_8320;
    localparam logic [CrcW-1:0]  CrcInit     = 32'hFFFF_FFFF;
    localparam logic [CrcW-1:0]  CrcXorOut   = 32'hFFFF_FFFF;
    localparam logic [ByteW-1:0] PayloadLenRst = 8'd100;
    localparam logic [ByteW-1:0] SyncFirstRst  = 8'hAA;
    localparam logic [ByteW-1:0] SyncSecondRst = 8'h55;
    localparam logic [PosW-1:0]  HeaderBytes   = 9'd3;
    localparam logic [PosW-1:0]  LastTrailerOfs = 9'd3;

    // configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_PAYLOAD_LENGTH = 2'd0,
        CFG_SYNC_FIRST     = 2'd1,
        CFG_SYNC_SECOND    = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic            frame_pass;
        logic            header_ok;
        logic            crc_ok;
        logic [CrcW-1:0] crc_received;
        logic [CrcW-1:0] crc_computed;
    } t_sfc_result;

endpackage

// File: rtl/sfc_if.sv
// valid/ready channel interfaces of the sync frame crc32 checker
interface sfc_byte_if import sfc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface sfc_result_if import sfc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            frame_pass;
    logic            header_ok;
    logic            crc_ok;
    logic [CrcW-1:0] crc_received;
    logic [CrcW-1:0] crc_computed;

    modport source (output valid, output frame_pass, output header_ok, output crc_ok,
                    output crc_received, output crc_computed, input ready);
    modport sink   (input valid, input frame_pass, input header_ok, input crc_ok,
                    input crc_received, input crc_computed, output ready);
endinterface

interface sfc_cfg_if import sfc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CfgIndexW-1:0] index;
    logic [ByteW-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sfc_frame_core.sv
// frame position tracking, header compare, crc update and trailer capture
module sfc_frame_core import sfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_write,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [ByteW-1:0]     i_cfg_data,
    input  logic                 i_accept,
    input  logic [ByteW-1:0]     i_data_byte,
    output logic                 o_push,
    output t_sfc_result          o_result
);

    // one byte through the reflected crc, bitwise unrolled
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
        for (int k = 0; k < ByteW; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

    logic [ByteW-1:0] r_payload_length;
    logic [ByteW-1:0] r_sync_first;
    logic [ByteW-1:0] r_sync_second;

    logic [PosW-1:0]  r_pos,     n_pos;
    logic [CrcW-1:0]  r_crc,     n_crc;
    logic             r_hdr,     n_hdr;
    logic [CrcW-1:0]  r_trailer, n_trailer;

    logic [PosW-1:0]  trailer_start;
    logic [PosW-1:0]  trailer_ofs;
    logic             frame_end;
    logic [CrcW-1:0]  computed;

    assign trailer_start = HeaderBytes + {1'b0, r_payload_length};
    assign trailer_ofs   = r_pos - trailer_start;
    assign computed      = r_crc ^ CrcXorOut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= PayloadLenRst;
            r_sync_first     <= SyncFirstRst;
            r_sync_second    <= SyncSecondRst;
        end else if (i_cfg_write) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PAYLOAD_LENGTH: r_payload_length <= i_cfg_data;
                CFG_SYNC_FIRST:     r_sync_first     <= i_cfg_data;
                CFG_SYNC_SECOND:    r_sync_second    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_pos     = r_pos + 9'd1;
        n_crc     = r_crc;
        n_hdr     = r_hdr;
        n_trailer = r_trailer;
        frame_end = 1'b0;
        priority if (r_pos == 9'd0) begin
            n_hdr = r_hdr & (i_data_byte == r_sync_first);
        end else if (r_pos == 9'd1) begin
            n_hdr = r_hdr & (i_data_byte == r_sync_second);
        end else if (r_pos < HeaderBytes) begin
            // length byte, not checked
        end else if (r_pos < trailer_start) begin
            n_crc = crc_byte(r_crc, i_data_byte);
        end else begin
            n_trailer = {i_data_byte, r_trailer[CrcW-1:ByteW]};
            frame_end = (trailer_ofs >= LastTrailerOfs);
        end
    end

    always_comb begin
        o_push                = i_accept & frame_end;
        o_result.crc_received = n_trailer;
        o_result.crc_computed = computed;
        o_result.crc_ok       = (computed == n_trailer);
        o_result.header_ok    = r_hdr;
        o_result.frame_pass   = r_hdr & (computed == n_trailer);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_crc     <= CrcInit;
            r_hdr     <= 1'b1;
            r_trailer <= '0;
        end else if (i_accept) begin
            if (frame_end) begin
                r_pos     <= '0;
                r_crc     <= CrcInit;
                r_hdr     <= 1'b1;
                r_trailer <= '0;
            end else begin
                r_pos     <= n_pos;
                r_crc     <= n_crc;
                r_hdr     <= n_hdr;
                r_trailer <= n_trailer;
            end
        end
    end

endmodule

// File: rtl/sfc_out_buffer.sv
// two-entry result register with skid slot
module sfc_out_buffer import sfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_sfc_result i_result,
    output logic        o_space,
    output logic        o_valid,
    input  logic        i_ready,
    output t_sfc_result o_result
);

    logic        r_main_valid;
    logic        r_skid_valid;
    t_sfc_result r_main;
    t_sfc_result r_skid;
    logic        pop;

    assign pop      = r_main_valid & i_ready;
    assign o_space  = ~r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= i_push;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end else if (!r_main_valid) begin
            r_main <= i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

// File: rtl/sync_frame_crc32_checker.sv
// top level of the sync frame crc32 checker
// Checks a received byte stream cut into fixed-length frames counted from
// reset: two sync bytes, a length byte that is ignored, payload_length payload
// bytes and a 4-byte little-endian crc. A reflected crc-32 (0xEDB88320, init
// all ones, final inversion) runs over the payload. One byte transaction is
// taken per clock unless stalled; the frame state and the unrolled 8-bit
// crc update sit between the input channel and a result register, so the
// result of a frame is registered when its last byte is accepted. The
// result side holds two entries (output register plus skid slot), so input
// stalls only while both hold untaken results. Registers: 0 payload_length
// (reset 100), 1 sync_first (reset 0xAA), 2 sync_second (reset 0x55); index
// 3 is ignored. Write configuration only while the block is idle.
module sync_frame_crc32_checker import sfc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sfc_cfg_if.sink      i_cfg_chan,
    sfc_byte_if.sink     i_byte_chan,
    sfc_result_if.source o_result_chan
);

    logic        byte_accept;
    logic        cfg_write;
    logic        push;
    logic        space;
    t_sfc_result core_result;
    t_sfc_result out_result;

    // configuration writes are always taken
    assign i_cfg_chan.ready = 1'b1;
    assign cfg_write        = i_cfg_chan.valid;

    // a byte is taken whenever a result slot is free
    assign i_byte_chan.ready = space;
    assign byte_accept       = i_byte_chan.valid & space;

    sfc_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (cfg_write),
        .i_cfg_index (i_cfg_chan.index),
        .i_cfg_data  (i_cfg_chan.data),
        .i_accept    (byte_accept),
        .i_data_byte (i_byte_chan.data_byte),
        .o_push      (push),
        .o_result    (core_result)
    );

    sfc_out_buffer u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_result),
        .o_space  (space),
        .o_valid  (o_result_chan.valid),
        .i_ready  (o_result_chan.ready),
        .o_result (out_result)
    );

    // unpack the result register onto the channel
    assign o_result_chan.frame_pass   = out_result.frame_pass;
    assign o_result_chan.header_ok    = out_result.header_ok;
    assign o_result_chan.crc_ok       = out_result.crc_ok;
    assign o_result_chan.crc_received = out_result.crc_received;
    assign o_result_chan.crc_computed = out_result.crc_computed;

endmodule
